### hw/rtl/prr_pkg.sv
// shared types and constants of the palette row resampler
// no dependencies
package prr_pkg;

   localparam int TEX_SIZE    = 256;
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [10:0] COLS_RESET = 11'd320;
   localparam logic [10:0] ROWS_RESET = 11'd240;
   localparam logic [10:0] COLS_MIN   = 11'd4;
   localparam logic [10:0] ROWS_MIN   = 11'd1;
   localparam logic [10:0] DIM_MAX    = 11'd1024;
   localparam logic [7:0]  ALPHA      = 8'hff;

   localparam logic KIND_PALETTE = 1'b0;
   localparam logic KIND_PIXEL   = 1'b1;

   localparam logic REG_SRC_COLS = 1'b0;
   localparam logic REG_SRC_ROWS = 1'b1;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } prr_pixel_type;

   typedef struct packed {
      logic [10:0] cols;
      logic [10:0] rows;
   } prr_geom_type;

endpackage

### hw/rtl/prr_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module prr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/prr_queue.sv
// short pixel queue between front and back
// depends on prr_pkg
module prr_queue import prr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  prr_pixel_type    push_data,
   input  logic             pop,
   output prr_pixel_type    head_data,
   output logic [CNT_W-1:0] count
);

   prr_pixel_type    slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = slot_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

### hw/rtl/prr_front.sv
// front: accepts items, writes palette entries, looks up pixel colours
// depends on prr_pkg, prr_ram
module prr_front import prr_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  logic             req_kind,
   input  logic [7:0]       req_entry_index,
   input  logic [7:0]       req_entry_red,
   input  logic [7:0]       req_entry_green,
   input  logic [7:0]       req_entry_blue,
   input  logic [7:0]       req_pixel_index,
   input  logic [CNT_W-1:0] q_count,
   output logic             q_push,
   output prr_pixel_type    q_data
);

   localparam int          AW        = $clog2(PALETTE_DEPTH);
   localparam logic [12:0] PAL_RECIP = 13'((65536 + PALETTE_DEPTH - 1) / PALETTE_DEPTH);
   localparam logic [8:0]  PAL_SIZE  = 9'(PALETTE_DEPTH);

   // index modulo depth by reciprocal multiply, exact for 8-bit values when PALETTE_DEPTH is at least 9
   function automatic logic [7:0] mod_index(input logic [7:0] value);
      logic [20:0] prod;
      logic [16:0] back;
      prod = 21'(value) * 21'(PAL_RECIP);
      back = 17'(prod[20:16]) * 17'(PAL_SIZE);
      mod_index = value - back[7:0];
   endfunction

   logic          accept;
   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    wr_idx;
   logic [7:0]    rd_idx;
   prr_pixel_type wr_color;
   logic [23:0]   rd_data;
   logic [CNT_W:0] fill;

   always_comb begin
      fill        = (CNT_W + 1)'(q_count) + (CNT_W + 1)'(s1_valid_ff);
      full        = fill >= (CNT_W + 1)'(QUEUE_DEPTH);
      accept      = push && !full;
      s1_valid_in = accept && (req_kind == KIND_PIXEL);
      wr_idx      = mod_index(req_entry_index);
      rd_idx      = mod_index(req_pixel_index);
      wr_color    = '{blue: req_entry_blue, green: req_entry_green, red: req_entry_red};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   prr_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (accept && (req_kind == KIND_PALETTE)),
      .wr_addr (wr_idx[AW-1:0]),
      .wr_data (wr_color),
      .rd_en   (s1_valid_in),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   assign q_push = s1_valid_ff;
   assign q_data = prr_pixel_type'(rd_data);

endmodule

### hw/rtl/prr_back.sv
// back: walks source position and emits the texel run of each pixel
// depends on prr_pkg
module prr_back import prr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             restart,
   input  prr_geom_type     geom,
   input  logic [CNT_W-1:0] q_count,
   input  prr_pixel_type    q_head,
   output logic             q_pop,
   input  logic             pop,
   output logic             empty,
   output logic [7:0]       rsp_out_row,
   output logic [7:0]       rsp_out_col,
   output logic [31:0]      rsp_texel,
   output logic             rsp_run_last
);

   logic          cur_valid_ff, cur_valid_in;
   prr_pixel_type cur_color_ff;
   logic [9:0]    src_col_ff, src_col_in;
   logic [9:0]    src_row_ff, src_row_in;
   logic [8:0]    out_row_ff, out_row_in;
   logic [8:0]    out_col_ff, out_col_in;
   logic [26:0]   acc_ff, acc_in;
   logic [18:0]   racc_ff, racc_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_row_ff, rsp_col_ff;
   logic [31:0]   rsp_texel_ff;
   logic          rsp_last_ff;

   logic [18:0] step;
   logic [26:0] pos, pos_nxt;
   logic [10:0] row_src, row_lim;
   logic        wide_rows;
   logic        active, cur_match, nxt_match;
   logic        slot_free, emit, finish, load;

   always_comb begin
      step      = {geom.cols, 8'b0};
      pos       = acc_ff + 27'({geom.cols, 7'b0});
      pos_nxt   = pos + 27'(step);
      wide_rows = geom.rows > 11'(TEX_SIZE);
      row_src   = wide_rows ? racc_ff[18:8] : {2'b0, out_row_ff};
      row_lim   = wide_rows ? 11'(TEX_SIZE) : geom.rows;
      active    = ({2'b0, out_row_ff} < row_lim) && (row_src == {1'b0, src_row_ff});
      cur_match = active && (out_col_ff < 9'(TEX_SIZE))
                  && (pos[26:16] == {1'b0, src_col_ff});
      nxt_match = (out_col_ff < 9'(TEX_SIZE - 1))
                  && (pos_nxt[26:16] == {1'b0, src_col_ff});
      slot_free = !rsp_valid_ff || pop;
      emit      = cur_valid_ff && cur_match && slot_free;
      finish    = cur_valid_ff && (!cur_match || (emit && !nxt_match));
      load      = (q_count != '0) && (!cur_valid_ff || finish);

      src_col_in = src_col_ff;
      src_row_in = src_row_ff;
      out_row_in = out_row_ff;
      out_col_in = out_col_ff;
      acc_in     = acc_ff;
      racc_in    = racc_ff;

      if (emit) begin
         out_col_in = out_col_ff + 9'd1;
         acc_in     = acc_ff + 27'(step);
      end
      if (finish) begin
         if ({1'b0, src_col_ff} >= geom.cols - 11'd1) begin
            src_col_in = '0;
            out_col_in = '0;
            acc_in     = '0;
            if (active) begin
               out_row_in = out_row_ff + 9'd1;
               racc_in    = racc_ff + 19'(geom.rows);
            end
            if ({1'b0, src_row_ff} >= geom.rows - 11'd1) begin
               src_row_in = '0;
               out_row_in = '0;
               racc_in    = '0;
            end else begin
               src_row_in = src_row_ff + 10'd1;
            end
         end else begin
            src_col_in = src_col_ff + 10'd1;
         end
      end
      if (restart) begin
         src_col_in = '0;
         src_row_in = '0;
         out_row_in = '0;
         out_col_in = '0;
         acc_in     = '0;
         racc_in    = '0;
      end

      if (load) begin
         cur_valid_in = 1'b1;
      end else if (finish) begin
         cur_valid_in = 1'b0;
      end else begin
         cur_valid_in = cur_valid_ff;
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         src_col_ff   <= '0;
         src_row_ff   <= '0;
         out_row_ff   <= '0;
         out_col_ff   <= '0;
         acc_ff       <= '0;
         racc_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         src_col_ff   <= src_col_in;
         src_row_ff   <= src_row_in;
         out_row_ff   <= out_row_in;
         out_col_ff   <= out_col_in;
         acc_ff       <= acc_in;
         racc_ff      <= racc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_color_ff <= q_head;
      end
      if (emit) begin
         rsp_row_ff   <= out_row_ff[7:0];
         rsp_col_ff   <= out_col_ff[7:0];
         rsp_texel_ff <= {ALPHA, cur_color_ff.blue, cur_color_ff.green, cur_color_ff.red};
         rsp_last_ff  <= !nxt_match;
      end
   end

   assign q_pop        = load;
   assign empty        = !rsp_valid_ff;
   assign rsp_out_row  = rsp_row_ff;
   assign rsp_out_col  = rsp_col_ff;
   assign rsp_texel    = rsp_texel_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

### hw/rtl/palette_row_resampler_top.sv
// Palettised nearest-neighbour scaler into a 256 x 256 RGBA texture. Items are
// palette writes or source pixels in row-major order; each pixel yields the texels
// of its run, one per cycle while the output is popped, the last one flagged. A
// palette write stays in the front; a pixel holds the back end until its run is
// done, so wide sources run at one pixel a cycle while the output is popped and
// narrow ones stall during runs. The palette lookup is registered in the front.
// Writing src_cols or src_rows restarts the frame position.
// depends on prr_pkg, prr_front, prr_queue, prr_back
module palette_row_resampler_top import prr_pkg::*; #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_kind,
   input  logic [7:0]  req_entry_index,
   input  logic [7:0]  req_entry_red,
   input  logic [7:0]  req_entry_green,
   input  logic [7:0]  req_entry_blue,
   input  logic [7:0]  req_pixel_index,
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_out_row,
   output logic [7:0]  rsp_out_col,
   output logic [31:0] rsp_texel,
   output logic        rsp_run_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   logic [10:0]      src_cols_ff, src_cols_in;
   logic [10:0]      src_rows_ff, src_rows_in;
   logic             csr_write;
   prr_geom_type     geom;
   logic             q_push, q_pop;
   prr_pixel_type    q_data, q_head;
   logic [CNT_W-1:0] q_count;

   always_comb begin
      csr_write   = psel && penable && pwrite && pready;
      src_cols_in = src_cols_ff;
      src_rows_in = src_rows_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_SRC_COLS: src_cols_in = pwdata[10:0];
            REG_SRC_ROWS: src_rows_in = pwdata[10:0];
            default:      src_cols_in = src_cols_ff;
         endcase
      end
      prdata = (paddr[2] == REG_SRC_ROWS) ? {21'b0, src_rows_ff} : {21'b0, src_cols_ff};

      if (src_cols_ff < COLS_MIN) begin
         geom.cols = COLS_MIN;
      end else if (src_cols_ff > DIM_MAX) begin
         geom.cols = DIM_MAX;
      end else begin
         geom.cols = src_cols_ff;
      end
      if (src_rows_ff < ROWS_MIN) begin
         geom.rows = ROWS_MIN;
      end else if (src_rows_ff > DIM_MAX) begin
         geom.rows = DIM_MAX;
      end else begin
         geom.rows = src_rows_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_cols_ff <= COLS_RESET;
         src_rows_ff <= ROWS_RESET;
      end else begin
         src_cols_ff <= src_cols_in;
         src_rows_ff <= src_rows_in;
      end
   end

   assign pready = 1'b1;

   prr_front #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_pixel_index (req_pixel_index),
      .q_count         (q_count),
      .q_push          (q_push),
      .q_data          (q_data)
   );

   prr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head_data (q_head),
      .count     (q_count)
   );

   prr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .restart      (csr_write),
      .geom         (geom),
      .q_count      (q_count),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .pop          (pop),
      .empty        (empty),
      .rsp_out_row  (rsp_out_row),
      .rsp_out_col  (rsp_out_col),
      .rsp_texel    (rsp_texel),
      .rsp_run_last (rsp_run_last)
   );

endmodule
